/* rtl/core/pjh_pkg.sv */
// Shared types and constants for the periodic jitter histogram.
// Holds the transaction payload structs and the item kind codes.
`default_nettype none
package pjh_pkg;

  localparam logic        REQ_READ     = 1'b1;
  localparam logic [31:0] PERIOD_RESET = 32'd80000;
  localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;
  localparam int          JIT_W        = 30;

  typedef struct packed {
    logic        req_type;
    logic [31:0] timestamp;
    logic [5:0]  bin_index;
  } pjh_in_t;

  typedef struct packed {
    logic             jitter_valid;
    logic [JIT_W-1:0] jitter_value;
    logic [JIT_W-1:0] max_jitter;
    logic [31:0]      bin_count;
  } pjh_out_t;

  typedef enum logic [1:0] {
    KIND_READ,
    KIND_FIRST,
    KIND_SAMPLE
  } pjh_kind_t;

endpackage
`default_nettype wire

/* rtl/core/pjh_hist.sv */
// Histogram bin store: one synchronous memory with a registered read port,
// write-to-read bypass and a clearing sweep after reset. Uses pjh_pkg.
`default_nettype none
module pjh_hist #(
  parameter int BINS = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            rd_en,
  input  wire logic [((BINS > 1) ? $clog2(BINS) : 1)-1:0] rd_addr,
  output logic [31:0]                          rd_data,
  input  wire logic                            wr_en,
  input  wire logic [((BINS > 1) ? $clog2(BINS) : 1)-1:0] wr_addr,
  input  wire logic [31:0]                     wr_data,
  output logic                                 clearing
);
  import pjh_pkg::*;

  localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;
  localparam logic [AW-1:0] LAST_BIN = AW'(BINS - 1);

  logic [31:0]   mem [BINS];
  logic [31:0]   rd_data_r;
  logic          clr_busy_r;
  logic          clr_busy_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic [AW-1:0] clr_cnt_nxt;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clr_busy_r) begin
      clr_cnt_nxt = clr_cnt_r + AW'(1);
      if (clr_cnt_r == LAST_BIN) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // bypass a write landing on the same bin in the same cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clr_busy_r;

  a_no_access_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (!wr_en && !rd_en))
    else $error("histogram accessed during clearing sweep");

  a_clear_full_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_busy_r) |-> ($past(clr_cnt_r) == LAST_BIN))
    else $error("clearing sweep ended early");

  a_clear_stays_done: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_busy_r |=> !clr_busy_r)
    else $error("clearing sweep restarted without reset");

endmodule
`default_nettype wire

/* rtl/core/periodic_jitter_histogram.sv */
// Path: an accepted transaction passes the s1 and s2 registers, then the output register.
// Throughput: one transaction per cycle unless out_ready or the clear stalls it, set by the
// histogram memory's separate read and write ports with a write-to-read bypass.
// Reset: synchronous; after rst_n rises in_ready stays low while the histogram clears,
// configuration writes are taken throughout.
// Top level of the periodic jitter histogram; uses pjh_pkg and pjh_hist.
`default_nettype none
module periodic_jitter_histogram #(
  parameter int BINS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pjh_pkg::pjh_in_t   in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pjh_pkg::pjh_out_t       out_data,
  input  wire logic               cfg_wr_en,
  input  wire logic [31:0]        cfg_wr_data
);
  import pjh_pkg::*;

  localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;

  logic [31:0]      period_r;
  logic [31:0]      prev_time_r;
  logic             seen_first_r;
  logic [JIT_W-1:0] max_jit_r;

  logic             s1_valid_r;
  pjh_kind_t        s1_kind_r;
  logic [31:0]      s1_diff_r;
  logic [5:0]       s1_idx_r;

  logic             s2_valid_r;
  pjh_kind_t        s2_kind_r;
  logic [JIT_W-1:0] s2_jit_r;
  logic [AW-1:0]    s2_addr_r;
  logic             s2_rd_ok_r;

  logic             out_valid_r;
  pjh_out_t         out_data_r;

  logic             in_accept;
  logic             out_free;
  logic             s1_adv;
  logic             s2_adv;
  logic             clearing;
  pjh_kind_t        s1_kind_nxt;

  logic [32:0]      dev_raw;
  logic [32:0]      dev;
  logic [JIT_W-1:0] s1_jit;
  logic [AW-1:0]    s1_bin;
  logic [AW-1:0]    rd_addr;
  logic             rd_en;
  logic             s1_rd_ok;
  logic [31:0]      rd_data;

  logic [31:0]      cnt_inc;
  logic             wr_en;
  logic [JIT_W-1:0] max_jit_nxt;
  pjh_out_t         out_data_nxt;

  assign out_free  = !out_valid_r || out_ready;
  assign s2_adv    = s2_valid_r && out_free;
  assign s1_adv    = s1_valid_r && (!s2_valid_r || s2_adv);
  assign in_ready  = !clearing && (!s1_valid_r || s1_adv);
  assign in_accept = in_valid && in_ready;

  always_comb begin
    if (in_data.req_type == REQ_READ) begin
      s1_kind_nxt = KIND_READ;
    end else if (seen_first_r) begin
      s1_kind_nxt = KIND_SAMPLE;
    end else begin
      s1_kind_nxt = KIND_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
    end else if (cfg_wr_en) begin
      period_r <= cfg_wr_data;
    end
  end

  // record time at acceptance so the next sample sees it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_first_r <= 1'b0;
      prev_time_r  <= '0;
    end else if (in_accept && (in_data.req_type != REQ_READ)) begin
      seen_first_r <= 1'b1;
      prev_time_r  <= in_data.timestamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_accept || (s1_valid_r && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_kind_r <= s1_kind_nxt;
      s1_diff_r <= in_data.timestamp - prev_time_r;
      s1_idx_r  <= in_data.bin_index;
    end
  end

  always_comb begin
    dev_raw = {1'b0, s1_diff_r} - {1'b0, period_r};
    dev     = dev_raw[32] ? (33'd0 - dev_raw) : dev_raw;
    s1_jit  = dev[32:3] + JIT_W'(dev[2]);
    if (s1_jit >= JIT_W'(BINS)) begin
      s1_bin = AW'(BINS - 1);
    end else begin
      s1_bin = s1_jit[AW-1:0];
    end
    s1_rd_ok = 32'(s1_idx_r) < 32'(BINS);
    rd_addr  = (s1_kind_r == KIND_READ) ? AW'(s1_idx_r) : s1_bin;
    rd_en    = s1_adv && (s1_kind_r != KIND_FIRST);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_adv || (s2_valid_r && !s2_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_kind_r  <= s1_kind_r;
      s2_jit_r   <= s1_jit;
      s2_addr_r  <= rd_addr;
      s2_rd_ok_r <= s1_rd_ok;
    end
  end

  pjh_hist #(
    .BINS (BINS)
  ) u_hist (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (s2_addr_r),
    .wr_data  (cnt_inc),
    .clearing (clearing)
  );

  always_comb begin
    cnt_inc     = (rd_data == COUNT_MAX) ? rd_data : (rd_data + 32'd1);
    wr_en       = s2_adv && (s2_kind_r == KIND_SAMPLE);
    max_jit_nxt = max_jit_r;
    if ((s2_kind_r == KIND_SAMPLE) && (s2_jit_r > max_jit_r)) begin
      max_jit_nxt = s2_jit_r;
    end
    out_data_nxt.max_jitter = max_jit_nxt;
    case (s2_kind_r)
      KIND_SAMPLE: begin
        out_data_nxt.jitter_valid = 1'b1;
        out_data_nxt.jitter_value = s2_jit_r;
        out_data_nxt.bin_count    = cnt_inc;
      end
      KIND_READ: begin
        out_data_nxt.jitter_valid = 1'b0;
        out_data_nxt.jitter_value = '0;
        out_data_nxt.bin_count    = s2_rd_ok_r ? rd_data : 32'd0;
      end
      default: begin
        out_data_nxt.jitter_valid = 1'b0;
        out_data_nxt.jitter_value = '0;
        out_data_nxt.bin_count    = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_jit_r <= '0;
    end else if (s2_adv) begin
      max_jit_r <= max_jit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_adv || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_max_covers_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.jitter_valid) |->
      (out_data.max_jitter >= out_data.jitter_value))
    else $error("max_jitter below reported jitter_value");

  a_sample_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.jitter_valid) |-> (out_data.bin_count != 32'd0))
    else $error("updated bin reported with zero count");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_ready)
    else $error("transaction accepted during histogram clear");

endmodule
`default_nettype wire

/* verif/periodic_jitter_histogram_test.sv */
// Self-checking testbench for periodic_jitter_histogram: directed and random
// sample and bin-read transactions under several period settings, with random idling.
// Depends on pjh_pkg and the periodic_jitter_histogram RTL.
module periodic_jitter_histogram_test;
  import pjh_pkg::*;

  localparam int          BINS         = 64;
  localparam logic        REQ_SAMPLE   = 1'b0;
  localparam logic [31:0] PERIOD_SLOW  = 32'hFFFF_FFFF;
  localparam logic [31:0] PERIOD_FAST  = 32'd1;
  localparam int          STUCK_LIMIT  = 2000;
  localparam int          RANDOM_ITEMS = 140;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  pjh_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  pjh_out_t    out_data;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;

  pjh_in_t     pending_items[$];
  pjh_out_t    jitter_expected[$];

  logic [31:0]      period_model;
  logic [31:0]      prev_time_model;
  logic             seen_first_model;
  logic [JIT_W-1:0] largest_model;
  logic [31:0]      hist_model[BINS];

  logic [31:0] gen_prev;
  bit          quiet;
  int          items_queued;
  int          results_seen;
  int          samples_sent;
  int          reads_sent;
  int          period_settings;
  int          mismatches;
  int          gap_left;
  int          stall_left;
  int          stuck_cycles;

  periodic_jitter_histogram #(.BINS(BINS)) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic pjh_out_t predict_jitter(input pjh_in_t req);
    pjh_out_t    res;
    logic [32:0] span;
    logic [32:0] dev;
    logic [32:0] rounded;
    int unsigned bin;
    res = '0;
    if (req.req_type == REQ_READ) begin
      res.bin_count = hist_model[req.bin_index];
    end else if (!seen_first_model) begin
      seen_first_model = 1'b1;
      prev_time_model = req.timestamp;
    end else begin
      span = {1'b0, req.timestamp - prev_time_model};
      dev = (span > {1'b0, period_model}) ? span - {1'b0, period_model}
                                         : {1'b0, period_model} - span;
      rounded = (dev + 33'd4) >> 3;
      prev_time_model = req.timestamp;
      if (rounded[JIT_W-1:0] > largest_model) largest_model = rounded[JIT_W-1:0];
      bin = (rounded >= BINS) ? BINS - 1 : int'(rounded);
      if (hist_model[bin] != COUNT_MAX) hist_model[bin] = hist_model[bin] + 1;
      res.jitter_valid = 1'b1;
      res.jitter_value = rounded[JIT_W-1:0];
      res.bin_count = hist_model[bin];
    end
    res.max_jitter = largest_model;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        jitter_expected.push_back(predict_jitter(in_data));
        if (in_data.req_type == REQ_READ) reads_sent++;
        else samples_sent++;
      end
      if (in_valid && !in_ready) begin
        // hold the transaction until accepted
      end else if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0 && !quiet && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 12);
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    pjh_out_t want;
    logic     ready_next;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (jitter_expected.size() == 0) begin
          $display("%0t: result with nothing expected, actual %h", $time, out_data);
          mismatches++;
        end else begin
          want = jitter_expected.pop_front();
          check_field("jitter_valid", 32'(want.jitter_valid), 32'(out_data.jitter_valid));
          check_field("jitter_value", 32'(want.jitter_value), 32'(out_data.jitter_value));
          check_field("max_jitter", 32'(want.max_jitter), 32'(out_data.max_jitter));
          check_field("bin_count", want.bin_count, out_data.bin_count);
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 12);
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      out_ready <= ready_next;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stuck_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic queue_sample(input logic [31:0] ts);
    pjh_in_t req;
    req.req_type = REQ_SAMPLE;
    req.timestamp = ts;
    req.bin_index = 6'($urandom);
    pending_items.push_back(req);
    gen_prev = ts;
    items_queued++;
  endtask

  task automatic queue_read(input logic [5:0] bin);
    pjh_in_t req;
    req.req_type = REQ_READ;
    req.timestamp = $urandom;
    req.bin_index = bin;
    pending_items.push_back(req);
    items_queued++;
  endtask

  task automatic queue_random(input int count);
    int pick;
    int off;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      off = int'($urandom_range(0, 1100)) - 550;
      if (pick < 20) queue_read(6'($urandom));
      else if (pick < 25) queue_sample($urandom);
      else queue_sample(gen_prev + period_model + 32'(off));
    end
  endtask

  task automatic settle();
    while (results_seen != items_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_period(input logic [31:0] p);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= p;
    period_model = p;
    period_settings++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    period_model = PERIOD_RESET;
    prev_time_model = '0;
    seen_first_model = 1'b0;
    largest_model = '0;
    for (int i = 0; i < BINS; i++) hist_model[i] = '0;
    gen_prev = '0;
    quiet = 1'b0;
    items_queued = 0;
    results_seen = 0;
    samples_sent = 0;
    reads_sent = 0;
    period_settings = 0;
    mismatches = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    write_period(PERIOD_RESET);
    queue_read(6'd0);
    queue_read(6'd63);
    queue_sample(32'hFFFF_FFF0);
    queue_sample(gen_prev + period_model);
    queue_sample(gen_prev + period_model + 32'd3);
    queue_sample(gen_prev + period_model + 32'd4);
    queue_sample(gen_prev + period_model - 32'd11);
    queue_sample(gen_prev + period_model + 32'd12);
    queue_sample(gen_prev + period_model - 32'd500);
    queue_sample(gen_prev + period_model + 32'd520);
    queue_sample(32'h0000_0000);
    queue_sample(32'hFFFF_FFFF);
    queue_sample(gen_prev);
    queue_read(6'd0);
    queue_read(6'd1);
    queue_read(6'd2);
    queue_read(6'd63);
    queue_read(6'b101010);
    queue_read(6'b010101);
    queue_random(RANDOM_ITEMS);

    write_period(PERIOD_FAST);
    queue_sample(gen_prev + 32'd1);
    queue_random(RANDOM_ITEMS);

    write_period(PERIOD_SLOW);
    queue_sample(gen_prev);
    queue_read(6'd63);
    queue_random(RANDOM_ITEMS);

    write_period(32'd1000);
    queue_random(RANDOM_ITEMS);

    write_period($urandom_range(2, 200000));
    queue_random(RANDOM_ITEMS);

    write_period(PERIOD_RESET);
    quiet = 1'b1;
    queue_random(RANDOM_ITEMS);

    settle();
    repeat (8) @(posedge clk);

    $display("Covered %0d jitter samples and %0d bin reads over %0d period settings,",
             samples_sent, reads_sent, period_settings);
    $display("including wrap, rounding edges, last-bin clamping and the largest jitter.");
    if (mismatches == 0 && jitter_expected.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
